// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

// File: rtl/core/tos_pkg.sv
package tos_pkg;

    // Default sizing
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int MAX_SHIFT_DEF   = 6;

    // Shift register
    localparam int              SHIFT_W     = 3;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd2;

    // Report kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // Converter commands
    localparam logic [1:0] CMD_CONVERT   = 2'd0;
    localparam logic [1:0] CMD_WAIT_DOWN = 2'd1;
    localparam logic [1:0] CMD_WAIT_UP   = 2'd2;

    // Input actions
    localparam logic ACT_PEN_CHECK = 1'b0;
    localparam logic ACT_CONV_DONE = 1'b1;

endpackage

// File: rtl/core/touch_oversample_sequencer.sv
// Touch panel sampling sequencer with oversampling average.
// An accepted transaction's result is registered in the output register, or in the skid entry while output stalls.
// Throughput: 1 transaction per cycle while in_stall is low; set by the single accumulate/shift stage.
// A two-entry output register (main + skid) lets input run while output stalls.
// Reset: sums and sample count cleared, shift_reg = 2, outputs invalid.
`include "assert_macros.svh"

module touch_oversample_sequencer #(
    parameter int SAMPLE_BITS = tos_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_SHIFT   = tos_pkg::MAX_SHIFT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_write_en,
    input  logic [tos_pkg::SHIFT_W-1:0]   cfg_write_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [SAMPLE_BITS-1:0]        x_sample,
    input  logic [SAMPLE_BITS-1:0]        y_sample,
    input  logic                          x_released,
    input  logic                          y_released,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    report_kind,
    output logic [SAMPLE_BITS-1:0]        x_position,
    output logic [SAMPLE_BITS-1:0]        y_position,
    output logic [1:0]                    adc_command,
    output logic                          tick_request
);

    localparam int SUM_W = SAMPLE_BITS + MAX_SHIFT;
    localparam int CNT_W = MAX_SHIFT + 1;
    localparam int SH_W  = tos_pkg::SHIFT_W;

    // Configuration and accumulator state
    logic [SH_W-1:0]        shift_reg;
    logic [SUM_W-1:0]       x_sum_reg, x_sum_next;
    logic [SUM_W-1:0]       y_sum_reg, y_sum_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    // Output register and skid entry
    logic                   out_valid_reg;
    logic [1:0]             kind_reg, kind_skid_reg;
    logic [SAMPLE_BITS-1:0] xpos_reg, xpos_skid_reg;
    logic [SAMPLE_BITS-1:0] ypos_reg, ypos_skid_reg;
    logic [1:0]             cmd_reg, cmd_skid_reg;
    logic                   tick_reg, tick_skid_reg;
    logic                   skid_valid_reg;

    // Per-transaction results
    logic [1:0]             kind_next;
    logic [SAMPLE_BITS-1:0] xpos_next;
    logic [SAMPLE_BITS-1:0] ypos_next;
    logic [1:0]             cmd_next;
    logic                   tick_next;

    logic [SH_W-1:0]        shift_eff;
    logic [CNT_W-1:0]       need;
    logic [CNT_W-1:0]       count_inc;
    logic                   not_full;
    logic [SUM_W-1:0]       x_shifted, y_shifted;
    logic [SUM_W-1:0]       pos_max;
    logic                   in_take, out_take;

    assign in_take  = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    // Shift above range acts as the maximum
    assign shift_eff = (int'(shift_reg) > MAX_SHIFT) ? SH_W'(MAX_SHIFT) : shift_reg;
    assign need      = CNT_W'(1) << shift_eff;
    assign not_full  = count_reg < need;
    assign count_inc = count_reg + CNT_W'(1);

    // Averages, saturated to the sample range
    assign pos_max   = SUM_W'({SAMPLE_BITS{1'b1}});
    assign x_shifted = x_sum_reg >> shift_eff;
    assign y_shifted = y_sum_reg >> shift_eff;

    // Sequencer decision and state update
    always_comb
    begin
        x_sum_next = x_sum_reg;
        y_sum_next = y_sum_reg;
        count_next = count_reg;
        kind_next  = tos_pkg::KIND_NONE;
        xpos_next  = '0;
        ypos_next  = '0;
        cmd_next   = tos_pkg::CMD_CONVERT;
        tick_next  = 1'b0;
        if (action == tos_pkg::ACT_CONV_DONE)
        begin
            // samples beyond a full set are dropped
            if (not_full)
            begin
                x_sum_next = x_sum_reg + SUM_W'(x_sample);
                y_sum_next = y_sum_reg + SUM_W'(y_sample);
                count_next = count_inc;
            end
            if (!(not_full && (count_inc < need)))
            begin
                cmd_next  = tos_pkg::CMD_WAIT_UP;
                tick_next = 1'b1;
            end
        end
        else if (!x_released && !y_released)
        begin
            // pen down: report if anything was collected
            if (count_reg != '0)
            begin
                kind_next = tos_pkg::KIND_PRESS;
                xpos_next = (x_shifted > pos_max) ? {SAMPLE_BITS{1'b1}}
                                                  : x_shifted[SAMPLE_BITS-1:0];
                ypos_next = (y_shifted > pos_max) ? {SAMPLE_BITS{1'b1}}
                                                  : y_shifted[SAMPLE_BITS-1:0];
            end
            x_sum_next = '0;
            y_sum_next = '0;
            count_next = '0;
        end
        else
        begin
            // pen up: release
            x_sum_next = '0;
            y_sum_next = '0;
            count_next = '0;
            kind_next  = tos_pkg::KIND_RELEASE;
            cmd_next   = tos_pkg::CMD_WAIT_DOWN;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg      <= tos_pkg::SHIFT_RESET;
            x_sum_reg      <= '0;
            y_sum_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                shift_reg <= cfg_write_data;
            end
            if (in_take)
            begin
                x_sum_reg <= x_sum_next;
                y_sum_reg <= y_sum_next;
                count_reg <= count_next;
            end
            if (skid_valid_reg && out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (in_take)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && out_take)
        begin
            kind_reg <= kind_skid_reg;
            xpos_reg <= xpos_skid_reg;
            ypos_reg <= ypos_skid_reg;
            cmd_reg  <= cmd_skid_reg;
            tick_reg <= tick_skid_reg;
        end
        else if (in_take && (!out_valid_reg || out_take))
        begin
            kind_reg <= kind_next;
            xpos_reg <= xpos_next;
            ypos_reg <= ypos_next;
            cmd_reg  <= cmd_next;
            tick_reg <= tick_next;
        end
        if (in_take && out_valid_reg && !out_take)
        begin
            kind_skid_reg <= kind_next;
            xpos_skid_reg <= xpos_next;
            ypos_skid_reg <= ypos_next;
            cmd_skid_reg  <= cmd_next;
            tick_skid_reg <= tick_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign report_kind  = kind_reg;
    assign x_position   = xpos_reg;
    assign y_position   = ypos_reg;
    assign adc_command  = cmd_reg;
    assign tick_request = tick_reg;

    // Checks
    `ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid without output")
    `ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= need || int'(count_reg) <= (1 << MAX_SHIFT), "sample count overflow")
    `ASSERT_NEXT(a_check_clears, clk, rst_n, in_take && action == tos_pkg::ACT_PEN_CHECK, count_reg == '0 && x_sum_reg == '0, "pen check left samples")
    `ASSERT_IMPLY(a_release_cmd, clk, rst_n, out_valid_reg && kind_reg == tos_pkg::KIND_RELEASE, cmd_reg == tos_pkg::CMD_WAIT_DOWN && !tick_reg, "release without wait pen down")

endmodule
